@@ src/radp_pkg.sv @@
// Shared constants and helpers for the radial desaturation pixel core.
// No dependencies; imported by radial_desaturate_pixel_core.
`default_nettype none

package radp_pkg;

  // Frame limits; positions beyond them are clamped.
  localparam int FRAME_WIDTH_MAX  = 4096;
  localparam int FRAME_HEIGHT_MAX = 4096;

  localparam int POS_W   = 12;
  localparam int CFG_W   = 12;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 24;
  localparam int OUT_W   = 32;
  localparam int SQ_W    = 2 * POS_W;       // one squared distance
  localparam int DIST_W  = SQ_W + 1;        // sum of two squares
  localparam int NUM_W   = DIST_W + CHAN_W; // distance times 255
  localparam int PROD_W  = 2 * CHAN_W;

  // Configuration register indexes.
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  localparam logic [CFG_W-1:0] CENTER_X_RESET = 12'd320;
  localparam logic [CFG_W-1:0] CENTER_Y_RESET = 12'd240;

  // Luma weights, summing to 255.
  localparam logic [PROD_W-1:0] LUMA_R = 16'd76;
  localparam logic [PROD_W-1:0] LUMA_G = 16'd150;
  localparam logic [PROD_W-1:0] LUMA_B = 16'd29;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA    = 8'hFF;

  // Pipeline layout: one quotient bit per divider stage.
  localparam int DIV_STEPS = CHAN_W;
  localparam int ST_DIV0   = 6;
  localparam int ST_MUL    = ST_DIV0 + DIV_STEPS;
  localparam int STAGES    = ST_MUL + 2;

  // Exact x / 255 for x below 65280.
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
    return t[PROD_W-1:CHAN_W];
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

@@ src/radial_desaturate_pixel_core.sv @@
// Radial vignette desaturation: blends each pixel toward its luma by its
// squared distance from a configurable centre. Depends on radp_pkg.
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// input    | in_valid / in_ready  | pos_x, pos_y, pixel_in
// output   | out_valid/ out_ready | pixel_out (ARGB, alpha 0xFF)
// config   | cfg_we               | cfg_index (0 center_x, 1 center_y)
//
// Sixteen register stages; one word per cycle is sustained while out_ready
// stays high. The weight divider, one quotient bit per stage over eight
// stages, sets the depth.
// Reset clears the valid bits and loads the centre registers (320, 240).
// Each stage holds while its successor is full and stalled; empty stages
// keep accepting, so bubbles close up and no word is lost or repeated.

module radial_desaturate_pixel_core import radp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [POS_W-1:0]  pos_x,
  input  wire logic [POS_W-1:0]  pos_y,
  input  wire logic [PIX_W-1:0]  pixel_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       pixel_out,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam logic [POS_W-1:0] X_LIMIT = POS_W'(FRAME_WIDTH_MAX - 1);
  localparam logic [POS_W-1:0] Y_LIMIT = POS_W'(FRAME_HEIGHT_MAX - 1);

  // Configuration and derived corner distance.
  logic [CFG_W-1:0]  center_x;
  logic [CFG_W-1:0]  center_y;
  logic [SQ_W-1:0]   cx2;
  logic [SQ_W-1:0]   cy2;
  logic [DIST_W-1:0] corner2;
  logic              corner_zero;

  // Stage valid bits and load enables.
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  // Stage 0: captured inputs.
  logic [POS_W-1:0]  s0_px;
  logic [POS_W-1:0]  s0_py;
  logic [PIX_W-1:0]  s0_pix;
  // Stage 1: distances and luma sum.
  logic [POS_W-1:0]  s1_dx;
  logic [POS_W-1:0]  s1_dy;
  logic [PROD_W-1:0] s1_lsum;
  logic [PIX_W-1:0]  s1_pix;
  // Stage 2: squares and luma.
  logic [SQ_W-1:0]   s2_dx2;
  logic [SQ_W-1:0]   s2_dy2;
  logic [CHAN_W-1:0] s2_luma;
  logic [PIX_W-1:0]  s2_pix;
  // Stage 3: squared distance.
  logic [DIST_W-1:0] s3_dist2;
  logic [CHAN_W-1:0] s3_luma;
  logic [PIX_W-1:0]  s3_pix;
  // Stage 4: dividend.
  logic [NUM_W-1:0]  s4_num;
  logic [CHAN_W-1:0] s4_luma;
  logic [PIX_W-1:0]  s4_pix;
  // Stage 5: saturation check.
  logic [NUM_W-1:0]  s5_rem;
  logic              s5_sat;
  logic [CHAN_W-1:0] s5_luma;
  logic [PIX_W-1:0]  s5_pix;
  // Divider stages.
  logic [NUM_W-1:0]  d_rem  [DIV_STEPS];
  logic [CHAN_W-1:0] d_q    [DIV_STEPS];
  logic              d_sat  [DIV_STEPS];
  logic [CHAN_W-1:0] d_luma [DIV_STEPS];
  logic [PIX_W-1:0]  d_pix  [DIV_STEPS];
  logic [NUM_W-1:0]  src_rem  [DIV_STEPS];
  logic [CHAN_W-1:0] src_q    [DIV_STEPS];
  logic              src_sat  [DIV_STEPS];
  logic [CHAN_W-1:0] src_luma [DIV_STEPS];
  logic [PIX_W-1:0]  src_pix  [DIV_STEPS];
  logic [NUM_W-1:0]  rem_next [DIV_STEPS];
  logic [CHAN_W-1:0] q_next   [DIV_STEPS];
  // Blend products: color times weight, luma times inverse weight.
  logic [PROD_W-1:0] m_cr;
  logic [PROD_W-1:0] m_cg;
  logic [PROD_W-1:0] m_cb;
  logic [PROD_W-1:0] m_lr;
  logic [PROD_W-1:0] m_lg;
  logic [PROD_W-1:0] m_lb;
  logic [OUT_W-1:0]  out_word;

  logic [CHAN_W-1:0] w_final;
  logic [CHAN_W-1:0] w_inv;
  logic [CHAN_W-1:0] last_luma;
  logic [PIX_W-1:0]  last_pix;

  // Config writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RESET;
      center_y <= CENTER_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Corner distance is registered from the registered centre squares; after a
  // write it settles well before any word reaches the divider.
  always_ff @(posedge clk) begin
    cx2         <= SQ_W'(center_x) * SQ_W'(center_x);
    cy2         <= SQ_W'(center_y) * SQ_W'(center_y);
    corner2     <= DIST_W'(cx2) + DIST_W'(cy2);
    corner_zero <= (cx2 == '0) && (cy2 == '0);
  end

  // Stage enables: load when empty or when the next stage moves too.
  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Front stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_px  <= (pos_x > X_LIMIT) ? X_LIMIT : pos_x;
      s0_py  <= (pos_y > Y_LIMIT) ? Y_LIMIT : pos_y;
      s0_pix <= pixel_in;
    end
    if (en[1]) begin
      s1_dx   <= abs_diff(s0_px, center_x);
      s1_dy   <= abs_diff(s0_py, center_y);
      s1_lsum <= LUMA_R * PROD_W'(s0_pix[23:16])
               + LUMA_G * PROD_W'(s0_pix[15:8])
               + LUMA_B * PROD_W'(s0_pix[7:0]);
      s1_pix  <= s0_pix;
    end
    if (en[2]) begin
      s2_dx2  <= SQ_W'(s1_dx) * SQ_W'(s1_dx);
      s2_dy2  <= SQ_W'(s1_dy) * SQ_W'(s1_dy);
      s2_luma <= div255(s1_lsum);
      s2_pix  <= s1_pix;
    end
    if (en[3]) begin
      s3_dist2 <= DIST_W'(s2_dx2) + DIST_W'(s2_dy2);
      s3_luma  <= s2_luma;
      s3_pix   <= s2_pix;
    end
    if (en[4]) begin
      // dist2 * 255 as a shift and subtract
      s4_num  <= {s3_dist2, {CHAN_W{1'b0}}} - NUM_W'(s3_dist2);
      s4_luma <= s3_luma;
      s4_pix  <= s3_pix;
    end
    if (en[5]) begin
      // quotient of 256 or more saturates the weight
      s5_sat  <= corner_zero || (s4_num >= {corner2, {CHAN_W{1'b0}}});
      s5_rem  <= s4_num;
      s5_luma <= s4_luma;
      s5_pix  <= s4_pix;
    end
  end

  // Restoring divider, one quotient bit per stage, MSB first.
  always_comb begin
    src_rem[0]  = s5_rem;
    src_q[0]    = '0;
    src_sat[0]  = s5_sat;
    src_luma[0] = s5_luma;
    src_pix[0]  = s5_pix;
    for (int j = 1; j < DIV_STEPS; j++) begin
      src_rem[j]  = d_rem[j-1];
      src_q[j]    = d_q[j-1];
      src_sat[j]  = d_sat[j-1];
      src_luma[j] = d_luma[j-1];
      src_pix[j]  = d_pix[j-1];
    end
  end

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      logic [NUM_W-1:0] dv;
      logic             ge;
      dv = NUM_W'(corner2) << (DIV_STEPS - 1 - j);
      ge = src_rem[j] >= dv;
      rem_next[j] = ge ? (src_rem[j] - dv) : src_rem[j];
      q_next[j] = src_q[j];
      q_next[j][3'(DIV_STEPS - 1 - j)] = ge;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en[ST_DIV0 + j]) begin
        d_rem[j]  <= rem_next[j];
        d_q[j]    <= q_next[j];
        d_sat[j]  <= src_sat[j];
        d_luma[j] <= src_luma[j];
        d_pix[j]  <= src_pix[j];
      end
    end
  end

  // Weight and blend products.
  assign w_final   = d_sat[DIV_STEPS-1] ? CHAN_MAX : d_q[DIV_STEPS-1];
  assign w_inv     = CHAN_MAX - w_final;
  assign last_luma = d_luma[DIV_STEPS-1];
  assign last_pix  = d_pix[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      m_cr <= PROD_W'(last_pix[23:16]) * PROD_W'(w_final);
      m_cg <= PROD_W'(last_pix[15:8])  * PROD_W'(w_final);
      m_cb <= PROD_W'(last_pix[7:0])   * PROD_W'(w_final);
      m_lr <= PROD_W'(last_luma) * PROD_W'(w_inv);
      m_lg <= PROD_W'(last_luma) * PROD_W'(w_inv);
      m_lb <= PROD_W'(last_luma) * PROD_W'(w_inv);
    end
  end

  // Output register: sum never exceeds 255*255, so it fits 16 bits.
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      out_word <= {ALPHA,
                   div255(m_cr + m_lr),
                   div255(m_cg + m_lg),
                   div255(m_cb + m_lb)};
    end
  end

  assign out_valid = v[STAGES-1];
  assign pixel_out = out_word;

endmodule

`default_nettype wire

@@ sim/tb_radial_desaturate_pixel_core.sv @@
// Self-checking testbench for radial_desaturate_pixel_core: drives pixel words
// with random gaps and stalls, predicts each ARGB word and compares in order.
// Depends on radp_pkg and radial_desaturate_pixel_core.
`timescale 1ns / 100ps

module tb_radial_desaturate_pixel_core;
  import radp_pkg::*;

  // Longest run of cycles with no word moving on either side.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 235;

  // Tracks the center registers and the queue of predicted ARGB words.
  class argb_tracker;
    typedef struct {
      bit [OUT_W-1:0] argb;
      bit [POS_W-1:0] x;
      bit [POS_W-1:0] y;
      bit [PIX_W-1:0] rgb;
    } pending_word_t;

    pending_word_t expected_argb_q[$];
    int unsigned ctr_x = 32'(CENTER_X_RESET);
    int unsigned ctr_y = 32'(CENTER_Y_RESET);
    int errors = 0;
    int checked = 0;

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_center(logic idx, int unsigned value);
      if (idx == REG_CENTER_X) ctr_x = value;
      else ctr_y = value;
    endfunction

    function int unsigned blend(int unsigned c, int unsigned luma, int unsigned w);
      return (c * w + luma * (255 - w)) / 255;
    endfunction

    // Weight by squared radius over squared corner radius, saturated at 255.
    function bit [OUT_W-1:0] desaturate(bit [POS_W-1:0] px, bit [POS_W-1:0] py,
                                        bit [PIX_W-1:0] rgb);
      int unsigned x, y, r, g, b, luma, w, dx, dy;
      longint unsigned d2, c2, wq;
      x = 32'(px);
      y = 32'(py);
      if (x > FRAME_WIDTH_MAX - 1) x = FRAME_WIDTH_MAX - 1;
      if (y > FRAME_HEIGHT_MAX - 1) y = FRAME_HEIGHT_MAX - 1;
      r = 32'(rgb[23:16]);
      g = 32'(rgb[15:8]);
      b = 32'(rgb[7:0]);
      luma = (76 * r + 150 * g + 29 * b) / 255;
      dx = (x >= ctr_x) ? x - ctr_x : ctr_x - x;
      dy = (y >= ctr_y) ? y - ctr_y : ctr_y - y;
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      c2 = longint'(ctr_x) * ctr_x + longint'(ctr_y) * ctr_y;
      if (c2 == 0) begin
        w = 255;
      end else begin
        wq = (d2 * 255) / c2;
        w = (wq > 255) ? 255 : int'(wq);
      end
      return {ALPHA, 8'(blend(r, luma, w)), 8'(blend(g, luma, w)), 8'(blend(b, luma, w))};
    endfunction

    function void note_pixel(bit [POS_W-1:0] px, bit [POS_W-1:0] py, bit [PIX_W-1:0] rgb);
      pending_word_t e;
      e.argb = desaturate(px, py, rgb);
      e.x = px;
      e.y = py;
      e.rgb = rgb;
      expected_argb_q.push_back(e);
    endfunction

    task check_argb(bit [OUT_W-1:0] got);
      pending_word_t e;
      if (expected_argb_q.size() == 0) begin
        report_mismatch($sformatf("output word %08h with nothing outstanding", got));
      end else begin
        e = expected_argb_q.pop_front();
        if (got !== e.argb)
          report_mismatch($sformatf(
            "word %0d (x %0d y %0d rgb %06h center %0d,%0d): got %08h want %08h",
            checked, e.x, e.y, e.rgb, ctr_x, ctr_y, got, e.argb));
      end
      checked++;
    endtask

    function int pending();
      return expected_argb_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [PIX_W-1:0] pixel_in;
  logic             out_valid;
  logic             out_ready;
  logic [OUT_W-1:0] pixel_out;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  argb_tracker tracker;

  // Idle odds per side, in percent; zero gives a gap-free stretch.
  int  src_idle_pct = 26;
  int  sink_idle_pct = 26;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit  hold_request = 1'b0;

  radial_desaturate_pixel_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one word: idle at random first, then hold valid and payload steady
  // until the block takes it. Called and left at a falling edge.
  task send_pixel(bit [POS_W-1:0] px, bit [POS_W-1:0] py, bit [PIX_W-1:0] rgb);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pos_x = px;
    pos_y = py;
    pixel_in = rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_pixel(px, py, rgb);
    @(negedge clk);
  endtask

  // Write both center registers, one per cycle. Only call with the pipe empty.
  task write_center(int unsigned cx, int unsigned cy);
    cfg_we = 1'b1;
    cfg_index = REG_CENTER_X;
    cfg_data = cx[CFG_W-1:0];
    tracker.set_center(REG_CENTER_X, cx);
    @(negedge clk);
    cfg_index = REG_CENTER_Y;
    cfg_data = cy[CFG_W-1:0];
    tracker.set_center(REG_CENTER_Y, cy);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid and hold until every predicted word has come back.
  task drain_pipe();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Mostly inside the frame that the center implies, some near the center,
  // some anywhere in the 12-bit range (far outside gives a saturated weight).
  function bit [POS_W-1:0] pick_coord(int unsigned ctr);
    int v;
    int unsigned span;
    span = (2 * ctr > 4095) ? 4095 : 2 * ctr;
    case ($urandom_range(9))
      0: v = $urandom_range(4095);
      1: begin
        v = int'(ctr) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      default: v = $urandom_range(span);
    endcase
    return v[POS_W-1:0];
  endfunction

  function bit [PIX_W-1:0] pick_rgb();
    bit [PIX_W-1:0] extremes[5] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                    24'h0000FF};
    if ($urandom_range(7) == 0) return extremes[$urandom_range(4)];
    return PIX_W'($urandom());
  endfunction

  // Receiver: pick ready at the falling edge, take the word at the rising edge.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= sink_idle_pct);
      end
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_argb(pixel_out);
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned cx_list[RAND_PHASES] = '{2048, 1, 0, 4095, 1, 2048, 640, 0};
    int unsigned cy_list[RAND_PHASES] = '{2048, 1, 0, 4095, 2048, 1, 360, 0};
    int unsigned cx, cy;
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words against the reset center (320, 240): dead center gives
    // full grey, the frame corners keep color, far positions saturate.
    send_pixel(12'd320, 12'd240, 24'hFFFFFF);
    send_pixel(12'd320, 12'd240, 24'h000000);
    send_pixel(12'd320, 12'd240, 24'hFF0000);
    send_pixel(12'd320, 12'd240, 24'h00FF00);
    send_pixel(12'd320, 12'd240, 24'h0000FF);
    send_pixel(12'd0, 12'd0, 24'h123456);
    send_pixel(12'd640, 12'd480, 24'hFF00FF);
    send_pixel(12'd0, 12'd480, 24'h00FFFF);
    send_pixel(12'd640, 12'd0, 24'hA5A55A);
    send_pixel(12'd4095, 12'd4095, 24'h5AA5A5);
    send_pixel(12'd4095, 12'd0, 24'hFFFF00);
    send_pixel(12'd0, 12'd4095, 24'h808080);
    send_pixel(12'd321, 12'd240, 24'hFEDCBA);
    send_pixel(12'd480, 12'd360, 24'h7F7F7F);
    send_pixel(12'd160, 12'd120, 24'h010203);
    send_pixel(12'd2730, 12'd1365, 24'hFFFFFE);
    drain_pipe();

    // Random phases, each with its own center; the list covers both extremes
    // and the zero-center case, the last phase rolls a fresh center.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      cx = cx_list[ph];
      cy = cy_list[ph];
      if (ph == RAND_PHASES - 1) begin
        cx = $urandom_range(1, 2048);
        cy = $urandom_range(1, 2048);
      end
      write_center(cx, cy);
      src_idle_pct = (ph == 3) ? 0 : 26;
      sink_idle_pct = (ph == 3) ? 0 : 26;
      // Stall the receiver while the sender keeps offering, to back up the pipe.
      if (ph == 1) hold_request = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_pixel(pick_coord(cx), pick_coord(cy), pick_rgb());
      drain_pipe();
    end

    repeat (STAGES + 8) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/radp_pkg.sv
src/radial_desaturate_pixel_core.sv
sim/tb_radial_desaturate_pixel_core.sv
